@@ src/pff_pkg.sv @@
// ----------------------------------------------------------------------------
// pff_pkg: potential field force package
// Shared types, constants and helpers for the potential field force block.
// ----------------------------------------------------------------------------
`default_nettype none

package pff_pkg;

   localparam int MAP_DIM     = 1024;
   localparam int COORD_W     = 10;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int FORCE_W     = 40;
   localparam int ACC_W       = 47;
   localparam int MUL_W       = 32;
   localparam int SQRT_IN_W   = 53;
   localparam int SQRT_OUT_W  = 27;
   localparam int DIV_NUM_W   = 106;
   localparam int DIV_DEN_W   = 81;
   localparam int DIST_SQ_W   = 21;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
      logic               is_background;
      logic [COORD_W-1:0] obstacle_row;
      logic [COORD_W-1:0] obstacle_col;
      logic               has_point;
      logic               end_of_obstacle;
      logic               end_of_pixel;
   } req_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic [COORD_W-1:0]        out_col;
      logic [COORD_W-1:0]        out_row;
   } rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTRACT_GAIN = 8'd0,
      CSR_REPULSE_GAIN = 8'd1,
      CSR_NEAR_LIMIT   = 8'd2,
      CSR_PIXEL_SCALE  = 8'd3,
      CSR_GOAL1_COL    = 8'd4,
      CSR_GOAL1_ROW    = 8'd5,
      CSR_GOAL2_COL    = 8'd6,
      CSR_GOAL2_ROW    = 8'd7
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   localparam logic signed [ACC_W-1:0] SAT_HI = 47'sd549755813887;
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 47'sd1;

   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (32'(v) >= MAP_DIM) r = COORD_W'(MAP_DIM - 1);
      else r = v;
      return r;
   endfunction

   function automatic logic signed [FORCE_W-1:0] sat_force(
      input logic signed [ACC_W-1:0] v);
      logic signed [FORCE_W-1:0] r;
      if (v > SAT_HI) r = SAT_HI[FORCE_W-1:0];
      else if (v < SAT_LO) r = SAT_LO[FORCE_W-1:0];
      else r = v[FORCE_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/pff_mul.sv @@
// ----------------------------------------------------------------------------
// pff_mul: shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_mul import pff_pkg::*; (
   input  wire logic               clock,
   input  wire logic [MUL_W-1:0]   mul_a,
   input  wire logic [MUL_W-1:0]   mul_b,
   output logic [2*MUL_W-1:0]      mul_p
);

   logic [2*MUL_W-1:0] prod_ff, prod_in;

   assign prod_in = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

@@ src/pff_sqrt.sv @@
// ----------------------------------------------------------------------------
// pff_sqrt: iterative square root
// Floor square root of a 53-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_sqrt import pff_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [SQRT_IN_W-1:0]  radicand,
   output logic [SQRT_OUT_W-1:0]      root,
   output unit_stat_type              stat
);

   logic [SQRT_IN_W-1:0] x_ff, x_in, bit_ff, bit_in;
   logic [SQRT_IN_W:0]   r_ff, r_in, trial;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic                 ge;

   always_comb begin
      trial   = r_ff + (SQRT_IN_W+1)'(bit_ff);
      ge      = (SQRT_IN_W+1)'(x_ff) >= trial;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         r_in    = '0;
         bit_in  = SQRT_IN_W'(1) << (SQRT_IN_W - 1);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            x_in = x_ff - trial[SQRT_IN_W-1:0];
            r_in = (r_ff >> 1) + (SQRT_IN_W+1)'(bit_ff);
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQRT_OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign root      = r_ff[SQRT_OUT_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ src/pff_div.sv @@
// ----------------------------------------------------------------------------
// pff_div: iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_div import pff_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIV_NUM_W-1:0]  numer,
   input  wire logic [DIV_DEN_W-1:0]  denom,
   output logic [DIV_NUM_W-1:0]       quot,
   output unit_stat_type              stat
);

   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] sub;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[DIV_NUM_W-1]};
      sub     = (DIV_DEN_W+2)'(rem_sh) - (DIV_DEN_W+2)'(den_ff);
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!sub[DIV_DEN_W+1]) begin
            rem_in = sub[DIV_DEN_W-1:0];
            q_in   = {q_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_DEN_W-1:0];
            q_in   = {q_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot      = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ src/potential_field_force.sv @@
// Each item passes S_IDLE, S_OBS and S_PIX; a point adds S_PT_A to S_PT_C.
// An obstacle end with repulsion adds a square root and four divisions, which
// dominate. A background pixel end adds S_AT_A to S_AT_C for each goal term.
// One item is worked on at a time; req_stall is high until it is finished.
// Reset is synchronous, active high, and restores the register defaults.
// ----------------------------------------------------------------------------
// potential_field_force: potential field force at one pixel
// Sequencer around a shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module potential_field_force import pff_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [28:0] {
      S_IDLE = 29'(1) << 0,  S_PT_A = 29'(1) << 1,  S_PT_B = 29'(1) << 2,
      S_PT_C = 29'(1) << 3,  S_OBS  = 29'(1) << 4,  S_MC   = 29'(1) << 5,
      S_MR   = 29'(1) << 6,  S_MC2  = 29'(1) << 7,  S_MR2  = 29'(1) << 8,
      S_SQ   = 29'(1) << 9,  S_SQW  = 29'(1) << 10, S_CHK  = 29'(1) << 11,
      S_DIVD = 29'(1) << 12, S_DIVL = 29'(1) << 13, S_D2   = 29'(1) << 14,
      S_D3A  = 29'(1) << 15, S_D3B  = 29'(1) << 16, S_D3C  = 29'(1) << 17,
      S_P    = 29'(1) << 18, S_PL   = 29'(1) << 19, S_NA   = 29'(1) << 20,
      S_NB   = 29'(1) << 21, S_NC   = 29'(1) << 22, S_NW   = 29'(1) << 23,
      S_PIX  = 29'(1) << 24, S_AT_A = 29'(1) << 25, S_AT_B = 29'(1) << 26,
      S_AT_C = 29'(1) << 27, S_OUT  = 29'(1) << 28
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]          attract_gain_ff, repulse_gain_ff, near_limit_ff;
   logic [15:0]          pixel_scale_ff;
   logic [COORD_W-1:0]   goal1_col_ff, goal1_row_ff, goal2_col_ff, goal2_row_ff;

   req_type              item_ff, item_in;
   logic [DIST_SQ_W-1:0] near_dist_ff, near_dist_in;
   logic [COORD_W-1:0]   near_row_ff, near_row_in, near_col_ff, near_col_in;
   logic                 near_valid_ff, near_valid_in;
   logic signed [FORCE_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [ACC_W-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic [1:0]           term_ff, term_in;
   logic                 comp_y_ff, comp_y_in;

   logic [57:0]          tmp_ff, tmp_in;
   logic [25:0]          mc_ff, mc_in, mr_ff, mr_in;
   logic [SQRT_OUT_W-1:0] dq_ff, dq_in;
   logic [32:0]          invd_ff, invd_in;
   logic [31:0]          diff_ff, diff_in;
   logic [53:0]          d2_ff, d2_in;
   logic [DIV_DEN_W-1:0] d3_ff, d3_in;
   logic [63:0]          p_ff, p_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [2*MUL_W-1:0]   mul_p;
   logic                 sqrt_start, div_start;
   logic [SQRT_IN_W-1:0] sqrt_x;
   logic [SQRT_OUT_W-1:0] sqrt_root;
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den;
   unit_stat_type        sqrt_stat, div_stat;

   logic [COORD_W-1:0]   pc, pr, adc_pt, adr_pt, adc_n, adr_n, at_p, at_g, at_a;
   logic                 neg_x, neg_y, at_neg;
   logic [DIST_SQ_W-1:0] d2_pt;
   logic [25:0]          m_sel;
   logic [42:0]          at_mag;
   logic [38:0]          rep_mag;
   logic signed [ACC_W-1:0] rep_sum;
   logic                 out_free;

   pff_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   pff_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_x),
      .root     (sqrt_root),
      .stat     (sqrt_stat)
   );

   pff_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attract_gain_ff <= 32'd65536;
         repulse_gain_ff <= 32'd65536;
         near_limit_ff   <= 32'd65536;
         pixel_scale_ff  <= 16'd655;
         goal1_col_ff    <= '0;
         goal1_row_ff    <= '0;
         goal2_col_ff    <= '0;
         goal2_row_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ATTRACT_GAIN: attract_gain_ff <= csr_wdata;
            CSR_REPULSE_GAIN: repulse_gain_ff <= csr_wdata;
            CSR_NEAR_LIMIT:   near_limit_ff   <= csr_wdata;
            CSR_PIXEL_SCALE:  pixel_scale_ff  <= csr_wdata[15:0];
            CSR_GOAL1_COL:    goal1_col_ff    <= clamp_coord(csr_wdata[COORD_W-1:0]);
            CSR_GOAL1_ROW:    goal1_row_ff    <= clamp_coord(csr_wdata[COORD_W-1:0]);
            CSR_GOAL2_COL:    goal2_col_ff    <= clamp_coord(csr_wdata[COORD_W-1:0]);
            CSR_GOAL2_ROW:    goal2_row_ff    <= clamp_coord(csr_wdata[COORD_W-1:0]);
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      pc     = item_ff.pixel_col;
      pr     = item_ff.pixel_row;
      adc_pt = (pc >= item_ff.obstacle_col) ? pc - item_ff.obstacle_col
                                            : item_ff.obstacle_col - pc;
      adr_pt = (pr >= item_ff.obstacle_row) ? pr - item_ff.obstacle_row
                                            : item_ff.obstacle_row - pr;
      neg_x  = pc < near_col_ff;
      neg_y  = pr < near_row_ff;
      adc_n  = neg_x ? near_col_ff - pc : pc - near_col_ff;
      adr_n  = neg_y ? near_row_ff - pr : pr - near_row_ff;
      d2_pt  = tmp_ff[DIST_SQ_W-1:0] + mul_p[DIST_SQ_W-1:0];
      m_sel  = comp_y_ff ? mr_ff : mc_ff;
      unique case (term_ff)
         2'd0:    begin at_p = pc; at_g = goal1_col_ff; end
         2'd1:    begin at_p = pc; at_g = goal2_col_ff; end
         2'd2:    begin at_p = pr; at_g = goal1_row_ff; end
         default: begin at_p = pr; at_g = goal2_row_ff; end
      endcase
      at_neg  = at_p > at_g;
      at_a    = at_neg ? at_p - at_g : at_g - at_p;
      at_mag  = 43'((59'(mul_p[57:0]) + 59'd32768) >> 16);
      rep_mag = (|div_quot[DIV_NUM_W-1:39]) ? SAT_HI[38:0] : div_quot[38:0];
      if (comp_y_ff)
         rep_sum = ACC_W'(sum_y_ff) + (neg_y ? -$signed(ACC_W'(rep_mag))
                                             : $signed(ACC_W'(rep_mag)));
      else
         rep_sum = ACC_W'(sum_x_ff) + (neg_x ? -$signed(ACC_W'(rep_mag))
                                             : $signed(ACC_W'(rep_mag)));
      out_free = !(rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      near_dist_in  = near_dist_ff;
      near_row_in   = near_row_ff;
      near_col_in   = near_col_ff;
      near_valid_in = near_valid_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      term_in       = term_ff;
      comp_y_in     = comp_y_ff;
      tmp_in        = tmp_ff;
      mc_in         = mc_ff;
      mr_in         = mr_ff;
      dq_in         = dq_ff;
      invd_in       = invd_ff;
      diff_in       = diff_ff;
      d2_in         = d2_ff;
      d3_in         = d3_ff;
      p_in          = p_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mul_a         = '0;
      mul_b         = '0;
      sqrt_start    = 1'b0;
      sqrt_x        = 53'(tmp_ff[51:0]) + 53'(mul_p[51:0]);
      div_start     = 1'b0;
      div_num       = DIV_NUM_W'(1) << 32;
      div_den       = DIV_DEN_W'(dq_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in              = req_data;
               item_in.pixel_col    = clamp_coord(req_data.pixel_col);
               item_in.pixel_row    = clamp_coord(req_data.pixel_row);
               item_in.obstacle_row = clamp_coord(req_data.obstacle_row);
               item_in.obstacle_col = clamp_coord(req_data.obstacle_col);
               ax_in    = '0;
               ay_in    = '0;
               term_in  = '0;
               state_in = req_data.has_point ? S_PT_A : S_OBS;
            end
         end
         S_PT_A: begin
            mul_a    = 32'(adc_pt);
            mul_b    = 32'(adc_pt);
            state_in = S_PT_B;
         end
         S_PT_B: begin
            mul_a    = 32'(adr_pt);
            mul_b    = 32'(adr_pt);
            tmp_in   = mul_p[57:0];
            state_in = S_PT_C;
         end
         S_PT_C: begin
            if (!near_valid_ff || d2_pt < near_dist_ff) begin
               near_dist_in  = d2_pt;
               near_row_in   = item_ff.obstacle_row;
               near_col_in   = item_ff.obstacle_col;
               near_valid_in = 1'b1;
            end
            state_in = S_OBS;
         end
         S_OBS: begin
            if (item_ff.end_of_obstacle && near_valid_ff) begin
               state_in = S_MC;
            end else begin
               if (item_ff.end_of_obstacle) begin
                  near_dist_in  = '1;
                  near_row_in   = '0;
                  near_col_in   = '0;
                  near_valid_in = 1'b0;
               end
               state_in = S_PIX;
            end
         end
         S_MC: begin
            mul_a    = 32'(adc_n);
            mul_b    = 32'(pixel_scale_ff);
            state_in = S_MR;
         end
         S_MR: begin
            mul_a    = 32'(adr_n);
            mul_b    = 32'(pixel_scale_ff);
            mc_in    = mul_p[25:0];
            state_in = S_MC2;
         end
         S_MC2: begin
            mr_in    = mul_p[25:0];
            mul_a    = 32'(mc_ff);
            mul_b    = 32'(mc_ff);
            state_in = S_MR2;
         end
         S_MR2: begin
            mul_a    = 32'(mr_ff);
            mul_b    = 32'(mr_ff);
            tmp_in   = mul_p[57:0];
            state_in = S_SQ;
         end
         S_SQ: begin
            sqrt_start = 1'b1;
            state_in   = S_SQW;
         end
         S_SQW: begin
            if (sqrt_stat.done) begin
               dq_in    = sqrt_root;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (dq_ff == '0 || 32'(dq_ff) > near_limit_ff) begin
               near_dist_in  = '1;
               near_row_in   = '0;
               near_col_in   = '0;
               near_valid_in = 1'b0;
               state_in      = S_PIX;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_stat.done) begin
               invd_in   = div_quot[32:0];
               div_start = 1'b1;
               div_den   = DIV_DEN_W'(near_limit_ff);
               state_in  = S_DIVL;
            end
         end
         S_DIVL: begin
            if (div_stat.done) begin
               diff_in  = 32'(invd_ff - div_quot[32:0]);
               state_in = S_D2;
            end
         end
         S_D2: begin
            mul_a    = 32'(dq_ff);
            mul_b    = 32'(dq_ff);
            state_in = S_D3A;
         end
         S_D3A: begin
            d2_in    = mul_p[53:0];
            mul_a    = 32'(mul_p[26:0]);
            mul_b    = 32'(dq_ff);
            state_in = S_D3B;
         end
         S_D3B: begin
            mul_a    = 32'(d2_ff[53:27]);
            mul_b    = 32'(dq_ff);
            tmp_in   = mul_p[57:0];
            state_in = S_D3C;
         end
         S_D3C: begin
            d3_in    = DIV_DEN_W'(tmp_ff[53:0]) + (DIV_DEN_W'(mul_p[53:0]) << 27);
            state_in = S_P;
         end
         S_P: begin
            mul_a    = repulse_gain_ff;
            mul_b    = diff_ff;
            state_in = S_PL;
         end
         S_PL: begin
            p_in      = mul_p;
            comp_y_in = 1'b0;
            state_in  = S_NA;
         end
         S_NA: begin
            mul_a    = p_ff[31:0];
            mul_b    = 32'(m_sel);
            state_in = S_NB;
         end
         S_NB: begin
            mul_a    = p_ff[63:32];
            mul_b    = 32'(m_sel);
            tmp_in   = mul_p[57:0];
            state_in = S_NC;
         end
         S_NC: begin
            div_num   = (DIV_NUM_W'(tmp_ff) + (DIV_NUM_W'(mul_p[57:0]) << 32)) << 16;
            div_den   = d3_ff;
            div_start = 1'b1;
            state_in  = S_NW;
         end
         S_NW: begin
            if (div_stat.done) begin
               if (comp_y_ff) begin
                  sum_y_in      = sat_force(rep_sum);
                  near_dist_in  = '1;
                  near_row_in   = '0;
                  near_col_in   = '0;
                  near_valid_in = 1'b0;
                  state_in      = S_PIX;
               end else begin
                  sum_x_in  = sat_force(rep_sum);
                  comp_y_in = 1'b1;
                  state_in  = S_NA;
               end
            end
         end
         S_PIX: begin
            if (!item_ff.end_of_pixel) state_in = S_IDLE;
            else if (item_ff.is_background) state_in = S_AT_A;
            else state_in = S_OUT;
         end
         S_AT_A: begin
            mul_a    = 32'(at_a);
            mul_b    = 32'(pixel_scale_ff);
            state_in = S_AT_B;
         end
         S_AT_B: begin
            mul_a    = attract_gain_ff;
            mul_b    = 32'(mul_p[25:0]);
            state_in = S_AT_C;
         end
         S_AT_C: begin
            if (term_ff[1])
               ay_in = at_neg ? ay_ff - $signed(ACC_W'(at_mag))
                              : ay_ff + $signed(ACC_W'(at_mag));
            else
               ax_in = at_neg ? ax_ff - $signed(ACC_W'(at_mag))
                              : ax_ff + $signed(ACC_W'(at_mag));
            term_in  = term_ff + 2'd1;
            state_in = (term_ff == 2'd3) ? S_OUT : S_AT_A;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.out_col = pc;
               rsp_in.out_row = pr;
               if (item_ff.is_background) begin
                  rsp_in.force_x = sat_force(ax_ff + ACC_W'(sum_x_ff));
                  rsp_in.force_y = sat_force(ay_ff + ACC_W'(sum_y_ff));
               end else begin
                  rsp_in.force_x = '0;
                  rsp_in.force_y = '0;
               end
               near_dist_in  = '1;
               near_row_in   = '0;
               near_col_in   = '0;
               near_valid_in = 1'b0;
               sum_x_in      = '0;
               sum_y_in      = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         near_dist_ff  <= '1;
         near_row_ff   <= '0;
         near_col_ff   <= '0;
         near_valid_ff <= 1'b0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         near_dist_ff  <= near_dist_in;
         near_row_ff   <= near_row_in;
         near_col_ff   <= near_col_in;
         near_valid_ff <= near_valid_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      term_ff   <= term_in;
      comp_y_ff <= comp_y_in;
      tmp_ff    <= tmp_in;
      mc_ff     <= mc_in;
      mr_ff     <= mr_in;
      dq_ff     <= dq_in;
      invd_ff   <= invd_in;
      diff_ff   <= diff_in;
      d2_ff     <= d2_in;
      d3_ff     <= d3_in;
      p_ff      <= p_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_near_clear: assert property (@(posedge clock) disable iff (reset)
      !near_valid_ff |-> (near_dist_ff == '1))
      else $error("nearest distance not at maximum while no point kept");

   a_sqrt_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQW) |-> (sqrt_stat.busy || sqrt_stat.done))
      else $error("waiting on an idle square root unit");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIVD || state_ff == S_DIVL || state_ff == S_NW))
      else $error("divider finished outside a wait state");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded on leaving output state");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: potential field force regression
// Drives pixel transactions with obstacle points through potential_field_force,
// predicts every force from its own fixed-point model of the block, and checks
// each response field by field under random bursts, gaps and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import pff_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'd200;
   localparam longint SAT_POS40 = 64'sd549755813887;
   localparam longint SAT_NEG40 = -64'sd549755813888;
   localparam int DRAIN_CYCLES = 700;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_ITEMS = 750;
   localparam int REQ_W = $bits(req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   potential_field_force dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [31:0] k_attract, k_repulse, near_lim;
   logic [15:0] scale;
   logic [9:0] g1_col, g1_row, g2_col, g2_row;
   logic [31:0] best_dist_sq;
   logic [9:0] best_row, best_col;
   bit best_valid;
   longint rep_x, rep_y;

   rsp_type expected_forces[$];
   int errors = 0;
   int cycles = 0;
   int stall_pct = 0;
   bit hold_start = 0;
   int hold_left = 0;
   int burst_left = 0;
   int gap_max = 0;
   int items_sent = 0;

   function automatic longint sat40(longint v);
      if (v > SAT_POS40) return SAT_POS40;
      if (v < SAT_NEG40) return SAT_NEG40;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint component_mag(longint unsigned p, longint unsigned m,
                                            longint unsigned d);
      logic [127:0] num, den, quo;
      num = (128'(p) * 128'(m)) << 16;
      den = 128'(d) * 128'(d) * 128'(d);
      quo = num / den;
      if (quo > 128'(SAT_POS40)) return SAT_POS40;
      return longint'(quo[63:0]);
   endfunction

   function automatic longint pull(logic [9:0] p, logic [9:0] g);
      int d;
      longint unsigned a, mag;
      d = int'(p) - int'(g);
      a = (d < 0) ? -d : d;
      mag = (64'(k_attract) * a * 64'(scale) + 64'd32768) >> 16;
      return (d > 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic void clear_best();
      best_dist_sq = 32'h1FFFFF;
      best_row = '0;
      best_col = '0;
      best_valid = 0;
   endfunction

   function automatic void add_push(logic [9:0] pc, logic [9:0] pr);
      int dc, dr;
      longint unsigned mc, mr, dq, inv_d, inv_l, p;
      longint fx, fy;
      dc = int'(pc) - int'(best_col);
      dr = int'(pr) - int'(best_row);
      mc = 64'((dc < 0) ? -dc : dc) * 64'(scale);
      mr = 64'((dr < 0) ? -dr : dr) * 64'(scale);
      dq = int_sqrt(mc * mc + mr * mr);
      if (dq == 0 || dq > 64'(near_lim)) return;
      inv_d = (64'd1 << 32) / dq;
      inv_l = (64'd1 << 32) / 64'(near_lim);
      p = 64'(k_repulse) * (inv_d - inv_l);
      fx = component_mag(p, mc, dq);
      fy = component_mag(p, mr, dq);
      rep_x = sat40(rep_x + ((dc < 0) ? -fx : fx));
      rep_y = sat40(rep_y + ((dr < 0) ? -fy : fy));
   endfunction

   function automatic void predict_force(req_type r);
      int dc, dr;
      logic [31:0] d2;
      longint fx, fy;
      rsp_type o;
      if (r.has_point) begin
         dc = int'(r.pixel_col) - int'(r.obstacle_col);
         dr = int'(r.pixel_row) - int'(r.obstacle_row);
         d2 = dc * dc + dr * dr;
         if (!best_valid || d2 < best_dist_sq) begin
            best_dist_sq = d2;
            best_row = r.obstacle_row;
            best_col = r.obstacle_col;
            best_valid = 1;
         end
      end
      if (r.end_of_obstacle) begin
         if (best_valid) add_push(r.pixel_col, r.pixel_row);
         clear_best();
      end
      if (!r.end_of_pixel) return;
      fx = 0;
      fy = 0;
      if (r.is_background) begin
         fx = sat40(pull(r.pixel_col, g1_col) + pull(r.pixel_col, g2_col) + rep_x);
         fy = sat40(pull(r.pixel_row, g1_row) + pull(r.pixel_row, g2_row) + rep_y);
      end
      o.force_x = fx[39:0];
      o.force_y = fy[39:0];
      o.out_col = r.pixel_col;
      o.out_row = r.pixel_row;
      expected_forces.push_back(o);
      clear_best();
      rep_x = 0;
      rep_y = 0;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
         CSR_ATTRACT_GAIN: k_attract = v;
         CSR_REPULSE_GAIN: k_repulse = v;
         CSR_NEAR_LIMIT: near_lim = v;
         CSR_PIXEL_SCALE: scale = v[15:0];
         CSR_GOAL1_COL: g1_col = v[9:0];
         CSR_GOAL1_ROW: g1_row = v[9:0];
         CSR_GOAL2_COL: g2_col = v[9:0];
         CSR_GOAL2_ROW: g2_row = v[9:0];
         default: ;
      endcase
   endfunction

   function automatic req_type mk(int pc, int pr, bit bg, int orow, int ocol,
                                  bit hp, bit eo, bit ep);
      req_type r;
      r.pixel_col = pc[9:0];
      r.pixel_row = pr[9:0];
      r.is_background = bg;
      r.obstacle_row = orow[9:0];
      r.obstacle_col = ocol[9:0];
      r.has_point = hp;
      r.end_of_obstacle = eo;
      r.end_of_pixel = ep;
      return r;
   endfunction

   // hold valid through a write; caller drops it after the batch
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      apply_reg(idx, v);
   endtask

   task automatic program_regs(logic [31:0] ka, logic [31:0] kr, logic [31:0] lim,
                               logic [31:0] s, logic [31:0] c1, logic [31:0] r1,
                               logic [31:0] c2, logic [31:0] r2);
      write_reg(CSR_ATTRACT_GAIN, ka);
      write_reg(CSR_REPULSE_GAIN, kr);
      write_reg(CSR_NEAR_LIMIT, lim);
      write_reg(CSR_PIXEL_SCALE, s);
      write_reg(CSR_GOAL1_COL, c1);
      write_reg(CSR_GOAL1_ROW, r1);
      write_reg(CSR_GOAL2_COL, c2);
      write_reg(CSR_GOAL2_ROW, r2);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      if (burst_left >= 0) req_valid <= 1'b0;
      burst_left = 0;
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(req_type r);
      int gap;
      if (gap_max > 0 && burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_force(r);
      items_sent++;
   endtask

   function automatic int near_coord(int base, int spread);
      int v;
      v = base + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > MAP_DIM - 1) v = MAP_DIM - 1;
      return v;
   endfunction

   task automatic send_pixel(bit noisy);
      int pc, pr, n_obs, n_pts, spread, pick;
      bit bg;
      pc = $urandom_range(0, MAP_DIM - 1);
      pr = $urandom_range(0, MAP_DIM - 1);
      bg = ($urandom_range(0, 99) < 85);
      n_obs = $urandom_range(0, 3);
      for (int o = 0; o < n_obs; o++) begin
         n_pts = $urandom_range(1, 4);
         pick = $urandom_range(0, 9);
         spread = (pick < 5) ? 60 : (pick < 8) ? 8 : (pick < 9) ? 0 : 1023;
         for (int k = 0; k < n_pts; k++) begin
            if (noisy && $urandom_range(0, 5) == 0)
               send_item(req_type'(REQ_W'({$urandom, $urandom})));
            else
               send_item(mk(pc, pr, bg, near_coord(pr, spread), near_coord(pc, spread),
                            !(noisy && $urandom_range(0, 7) == 0),
                            k == n_pts - 1 && !(noisy && $urandom_range(0, 5) == 0),
                            0));
         end
      end
      send_item(mk(pc, pr, bg, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1), $urandom_range(0, 1), 1));
   endtask

   task automatic random_regs();
      logic [31:0] ka, kr, lim, s;
      case ($urandom_range(0, 3))
         0: ka = 32'hFFFF_FFFF;
         1: ka = $urandom;
         default: ka = $urandom_range(0, 32'h0004_0000);
      endcase
      case ($urandom_range(0, 3))
         0: kr = 32'hFFFF_FFFF;
         1: kr = $urandom;
         default: kr = $urandom_range(0, 32'h0010_0000);
      endcase
      case ($urandom_range(0, 4))
         0: lim = 32'hFFFF_FFFF;
         1: lim = $urandom_range(1, 32'h0000_4000);
         default: lim = $urandom_range(32'h0000_4000, 32'h0008_0000);
      endcase
      s = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535) : $urandom_range(100, 4000);
      program_regs(ka, kr, lim, s, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_directed();
      gap_max = 0;
      stall_pct = 0;
      send_item(mk(0, 0, 1, 0, 0, 0, 0, 1));
      send_item(mk(1023, 1023, 1, 1023, 1023, 0, 0, 1));
      send_item(mk(500, 500, 1, 500, 500, 1, 1, 1));
      send_item(mk(500, 500, 0, 520, 510, 1, 1, 1));
      send_item(mk(300, 300, 1, 310, 300, 1, 0, 0));
      send_item(mk(300, 300, 1, 300, 310, 1, 0, 0));
      send_item(mk(300, 300, 1, 290, 300, 1, 1, 0));
      send_item(mk(300, 300, 1, 0, 0, 0, 1, 0));
      send_item(mk(300, 300, 1, 340, 340, 1, 1, 0));
      send_item(mk(300, 300, 1, 900, 900, 1, 1, 1));
      send_item(mk(100, 900, 1, 905, 102, 1, 0, 0));
      send_item(mk(100, 900, 1, 0, 0, 0, 0, 1));
      send_item(mk(1023, 0, 1, 1, 1020, 1, 1, 0));
      send_item(mk(1023, 0, 1, 0, 1023, 1, 0, 1));
      send_item(mk(0, 1023, 1, 1023, 1, 1, 1, 1));
      send_item(mk(700, 200, 1, 203, 696, 1, 1, 0));
      send_item(mk(700, 200, 1, 190, 700, 1, 1, 0));
      send_item(mk(700, 200, 1, 200, 712, 1, 1, 1));
      drain();
   endtask

   task automatic test_extremes();
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535,
                   32'd1023, 32'd0, 32'd0, 32'd1023);
      test_directed();
      program_regs(32'd0, 32'd1, 32'd1, 32'd1, 32'd512, 32'd511, 32'hFFFF_FC05, 32'd7);
      write_reg(CSR_UNUSED, 32'hDEAD_BEEF);
      csr_valid <= 1'b0;
      @(posedge clock);
      test_directed();
      program_regs(32'h0001_8000, 32'h0200_0000, 32'h0002_0000, 32'd655,
                   32'd200, 32'd800, 32'd900, 32'd100);
      test_directed();
   endtask

   task automatic test_backpressure();
      gap_max = 0;
      hold_start = 1;
      for (int i = 0; i < 30; i++)
         send_item(mk($urandom_range(0, 1023), $urandom_range(0, 1023), 1,
                      $urandom_range(0, 1023), $urandom_range(0, 1023), 0, 0, 1));
      drain();
   endtask

   task automatic test_random();
      int phase;
      phase = 0;
      while (items_sent < RANDOM_ITEMS - 60) begin
         if (phase % 4 == 0) begin
            gap_max = 0;
            stall_pct = 0;
         end else begin
            gap_max = $urandom_range(1, 12);
            stall_pct = $urandom_range(10, 70);
         end
         for (int n = 0; n < 25; n++) send_pixel(phase % 3 == 2);
         drain();
         random_regs();
         phase++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_forces.size() == 0) begin
               $display("%0t: unexpected transaction %h", $time, rsp_data);
               errors++;
            end else begin
               want = expected_forces.pop_front();
               if (rsp_data.force_x !== want.force_x) begin
                  $display("%0t: force_x expected %0d got %0d", $time,
                           want.force_x, rsp_data.force_x);
                  errors++;
               end
               if (rsp_data.force_y !== want.force_y) begin
                  $display("%0t: force_y expected %0d got %0d", $time,
                           want.force_y, rsp_data.force_y);
                  errors++;
               end
               if (rsp_data.out_col !== want.out_col) begin
                  $display("%0t: out_col expected %0d got %0d", $time,
                           want.out_col, rsp_data.out_col);
                  errors++;
               end
               if (rsp_data.out_row !== want.out_row) begin
                  $display("%0t: out_row expected %0d got %0d", $time,
                           want.out_row, rsp_data.out_row);
                  errors++;
               end
            end
         end
         if (hold_start) begin
            hold_start = 0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      k_attract = 32'h0001_0000;
      k_repulse = 32'h0001_0000;
      near_lim = 32'h0001_0000;
      scale = 16'd655;
      g1_col = '0;
      g1_row = '0;
      g2_col = '0;
      g2_row = '0;
      clear_best();
      rep_x = 0;
      rep_y = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_extremes();
      test_backpressure();
      test_random();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && expected_forces.size() != 0 && rsp_valid === 1'bx) begin
         $display("%0t: rsp_valid unknown", $time);
         errors++;
      end
   end

endmodule

`default_nettype wire
